### hdl/eight_bit_alu_with_flags_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the eight-bit ALU unit
// Concurrent check shorthands clocked on clk, with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef EIGHT_BIT_ALU_WITH_FLAGS_UNIT_MACROS_SVH
`define EIGHT_BIT_ALU_WITH_FLAGS_UNIT_MACROS_SVH

// Same-cycle implication, off while rst is high.
`define ALU8F_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("alu8f: same-cycle check failed");

// Next-cycle implication, off while rst is high.
`define ALU8F_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("alu8f: next-cycle check failed");

// Next-cycle implication that also holds across reset.
`define ALU8F_ASSERT_NEXT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("alu8f: reset check failed");

`endif

### hdl/alu8f_pkg.sv
// ----------------------------------------------------------------------------
// alu8f_pkg
// Operation codes and word types shared by the eight-bit ALU unit.
// ----------------------------------------------------------------------------
package alu8f_pkg;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_CMP  = 4'd2,
    OP_AND  = 4'd3,
    OP_OR   = 4'd4,
    OP_XOR  = 4'd5,
    OP_SHL  = 4'd6,
    OP_SHR  = 4'd7,
    OP_ROL  = 4'd8,
    OP_ROR  = 4'd9,
    OP_INC  = 4'd10,
    OP_DEC  = 4'd11,
    OP_BIT  = 4'd12,
    OP_LOAD = 4'd13
  } op_t;

  typedef struct packed {
    logic [3:0] op;
    logic [7:0] reg_value;
    logic [7:0] operand;
    logic       carry_in;
    logic       overflow_in;
    logic       negative_in;
    logic       zero_in;
  } alu_in_t;

  typedef struct packed {
    logic [7:0] result;
    logic       negative_out;
    logic       zero_out;
    logic       carry_out;
    logic       overflow_out;
  } alu_out_t;

  localparam int unsigned IN_W  = $bits(alu_in_t);
  localparam int unsigned OUT_W = $bits(alu_out_t);

endpackage

### hdl/alu8f_stage.sv
// ----------------------------------------------------------------------------
// alu8f_stage
// One pipeline register with valid and stall; passes stall upstream only
// when it holds a word that cannot move on.
// ----------------------------------------------------------------------------
module alu8f_stage #(
  parameter int unsigned W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         up_valid,
  output logic         up_stall,
  input  logic [W-1:0] up_data,
  output logic         dn_valid,
  input  logic         dn_stall,
  output logic [W-1:0] dn_data
);

  logic         valid;
  logic [W-1:0] data;

  assign up_stall = valid & dn_stall;
  assign dn_valid = valid;
  assign dn_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!up_stall) begin
      valid <= up_valid;
    end
  end

  // hold the word while stalled
  always_ff @(posedge clk) begin
    if (!up_stall && up_valid) begin
      data <= up_data;
    end
  end

endmodule

### hdl/alu8f_core.sv
// ----------------------------------------------------------------------------
// alu8f_core
// Combinational byte datapath: adders, logic and shift unit, flag update.
// ----------------------------------------------------------------------------
module alu8f_core (
  input  alu8f_pkg::alu_in_t  din,
  output alu8f_pkg::alu_out_t dout
);
  import alu8f_pkg::*;

  logic [7:0] r;
  logic [7:0] m;
  logic [7:0] m_add;
  logic [8:0] sum;
  logic [8:0] diff;
  logic [7:0] res;
  logic       n;
  logic       z;
  logic       c;
  logic       v;
  logic       nz;

  assign r     = din.reg_value;
  assign m     = din.operand;
  assign m_add = (din.op == OP_SUB) ? ~m : m;
  assign sum   = {1'b0, r} + {1'b0, m_add} + {8'd0, din.carry_in};
  // bit 8 set means no borrow, i.e. r >= m
  assign diff  = {1'b0, r} + {1'b0, ~m} + 9'd1;

  always_comb begin
    res = r;
    n   = din.negative_in;
    z   = din.zero_in;
    c   = din.carry_in;
    v   = din.overflow_in;
    nz  = 1'b1;
    case (din.op)
      OP_ADD, OP_SUB: begin
        res = sum[7:0];
        v   = (r[7] ^ sum[7]) & (m_add[7] ^ sum[7]);
        c   = sum[8];
      end
      OP_CMP: begin
        z  = (r == m);
        c  = diff[8];
        n  = diff[7];
        nz = 1'b0;
      end
      OP_AND:  res = r & m;
      OP_OR:   res = r | m;
      OP_XOR:  res = r ^ m;
      OP_SHL: begin
        c   = m[7];
        res = {m[6:0], 1'b0};
      end
      OP_SHR: begin
        c   = m[0];
        res = {1'b0, m[7:1]};
      end
      OP_ROL: begin
        c   = m[7];
        res = {m[6:0], din.carry_in};
      end
      OP_ROR: begin
        c   = m[0];
        res = {din.carry_in, m[7:1]};
      end
      OP_INC:  res = m + 8'd1;
      OP_DEC:  res = m - 8'd1;
      OP_BIT: begin
        n  = m[7];
        v  = m[6];
        z  = ((m & r) == 8'd0);
        nz = 1'b0;
      end
      OP_LOAD: res = m;
      default: begin
        // unused codes: pass register and flags through
        nz = 1'b0;
      end
    endcase
    if (nz) begin
      n = res[7];
      z = (res == 8'd0);
    end
  end

  assign dout.result       = res;
  assign dout.negative_out = n;
  assign dout.zero_out     = z;
  assign dout.carry_out    = c;
  assign dout.overflow_out = v;

endmodule

### hdl/eight_bit_alu_with_flags_unit.sv
// ----------------------------------------------------------------------------
// eight_bit_alu_with_flags_unit
// Eight-bit ALU with N, Z, C and V flags, binary mode, two register stages.
// ----------------------------------------------------------------------------
// Usage:
//   Operation channel (op_valid / op_stall / op_word) carries the operation
//   code, register value, operand byte and the current flags. Result channel
//   (res_valid / res_stall / res_word) returns the result byte and new flags.
//   A word is taken at a clock edge with valid high and stall low.
// Path: a word taken by the input register passes the core into the result
//   register and then appears on res_word; one result per input word.
// Throughput: one word per cycle while res_stall is low, set by the single-pass
//   byte datapath between the input register and the result register.
// Stall: with res_stall high the result register holds its word; the input
//   register keeps taking words until it too is full, then op_stall rises.
// Reset: rst (synchronous) empties both registers; op_stall is low and
//   res_valid is low in the cycle after reset.
// ----------------------------------------------------------------------------
module eight_bit_alu_with_flags_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                op_valid,
  output logic                op_stall,
  input  alu8f_pkg::alu_in_t  op_word,
  output logic                res_valid,
  input  logic                res_stall,
  output alu8f_pkg::alu_out_t res_word
);
  import alu8f_pkg::*;

  logic             mid_valid;
  logic             mid_stall;
  logic [IN_W-1:0]  mid_data;
  alu_in_t          core_in;
  alu_out_t         core_out;
  logic [OUT_W-1:0] res_data;

  alu8f_stage #(.W(IN_W)) u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .up_valid (op_valid),
    .up_stall (op_stall),
    .up_data  (op_word),
    .dn_valid (mid_valid),
    .dn_stall (mid_stall),
    .dn_data  (mid_data)
  );

  assign core_in = alu_in_t'(mid_data);

  alu8f_core u_core (
    .din  (core_in),
    .dout (core_out)
  );

  alu8f_stage #(.W(OUT_W)) u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .up_valid (mid_valid),
    .up_stall (mid_stall),
    .up_data  (core_out),
    .dn_valid (res_valid),
    .dn_stall (res_stall),
    .dn_data  (res_data)
  );

  assign res_word = alu_out_t'(res_data);

endmodule

### hdl/alu8f_checker.sv
// ----------------------------------------------------------------------------
// alu8f_checker
// Port-level checks on the eight-bit ALU unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "eight_bit_alu_with_flags_unit_macros.svh"

module alu8f_checker (
  input logic                clk,
  input logic                rst,
  input logic                op_valid,
  input logic                op_stall,
  input logic                res_valid,
  input logic                res_stall,
  input alu8f_pkg::alu_out_t res_word
);

  // a stalled result stays put
  `ALU8F_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res_word))

  // backpressure only ever comes from the result side
  `ALU8F_ASSERT_NOW(a_stall_src, op_stall, res_stall)

  // a taken word that the receiver does not stall reaches the result register and is shown
  `ALU8F_ASSERT_NEXT(a_latency, (op_valid && !op_stall) ##1 !res_stall, res_valid)

  // reset empties the pipe
  `ALU8F_ASSERT_NEXT_ALWAYS(a_reset, rst, !res_valid && !op_stall)

endmodule

bind eight_bit_alu_with_flags_unit alu8f_checker u_alu8f_checker (.*);

### sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the eight-bit ALU unit: a directed table of operations and
// flag corner cases, then random words across several idle and stall mixes,
// each result compared field by field with its typed result or an in-bench flag predictor.
// ----------------------------------------------------------------------------
module tb;
  import alu8f_pkg::*;

  // Spare operation codes: the unit treats them as no operation
  localparam logic [3:0] OP_SPARE_E = 4'd14;
  localparam logic [3:0] OP_SPARE_F = 4'd15;

  localparam int NUM_RANDOM   = 400;
  localparam int NUM_PHASES   = 5;
  localparam int HANG_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 4;
  localparam int MAX_REPORTS  = 10;

  // One table row: the word, whether a result is typed in, and that result
  typedef struct packed {
    alu_in_t  word;
    logic     typed;
    alu_out_t want;
  } alu_case_t;

  // Row layout: {op, reg_value, operand, {c, v, n, z} in, typed,
  //              result, {n, z, c, v} out}
  localparam alu_case_t DIRECTED_CASES [25] = '{
    {OP_ADD,     8'h00, 8'h00, 4'b0110, 1'b1, 8'h00, 4'b0100},
    {OP_ADD,     8'hFF, 8'hFF, 4'b1001, 1'b1, 8'hFF, 4'b1010},
    {OP_ADD,     8'h7F, 8'h01, 4'b0000, 1'b1, 8'h80, 4'b1001},
    {OP_ADD,     8'h80, 8'h80, 4'b0000, 1'b1, 8'h00, 4'b0111},
    {OP_SUB,     8'h50, 8'hF0, 4'b1100, 1'b0, 12'h000},
    {OP_SUB,     8'h00, 8'h01, 4'b1001, 1'b0, 12'h000},
    {OP_SUB,     8'h80, 8'h01, 4'b1010, 1'b0, 12'h000},
    {OP_CMP,     8'h40, 8'h40, 4'b0110, 1'b1, 8'h40, 4'b0111},
    {OP_CMP,     8'h00, 8'hFF, 4'b1011, 1'b0, 12'h000},
    {OP_CMP,     8'hFF, 8'h00, 4'b0001, 1'b0, 12'h000},
    {OP_AND,     8'hFF, 8'h00, 4'b1110, 1'b1, 8'h00, 4'b0111},
    {OP_OR,      8'h00, 8'h80, 4'b0001, 1'b1, 8'h80, 4'b1000},
    {OP_XOR,     8'hA5, 8'h5A, 4'b1001, 1'b0, 12'h000},
    {OP_SHL,     8'h00, 8'h80, 4'b0010, 1'b1, 8'h00, 4'b0110},
    {OP_SHR,     8'h00, 8'h01, 4'b0110, 1'b0, 12'h000},
    {OP_SHR,     8'hFF, 8'hFF, 4'b0001, 1'b0, 12'h000},
    {OP_ROL,     8'h00, 8'h80, 4'b1000, 1'b0, 12'h000},
    {OP_ROR,     8'h00, 8'h01, 4'b1000, 1'b0, 12'h000},
    {OP_INC,     8'h00, 8'hFF, 4'b0110, 1'b1, 8'h00, 4'b0101},
    {OP_DEC,     8'h00, 8'h00, 4'b1001, 1'b0, 12'h000},
    {OP_BIT,     8'h0F, 8'hC0, 4'b1000, 1'b0, 12'h000},
    {OP_BIT,     8'hFF, 8'h3F, 4'b0111, 1'b0, 12'h000},
    {OP_LOAD,    8'h55, 8'h00, 4'b1110, 1'b0, 12'h000},
    {OP_SPARE_E, 8'hAB, 8'h12, 4'b1111, 1'b1, 8'hAB, 4'b1111},
    {OP_SPARE_F, 8'h00, 8'hFF, 4'b0000, 1'b1, 8'h00, 4'b0000}
  };

  localparam int SEND_IDLE_PCT [NUM_PHASES] = '{0, 70, 0, 17, 0};
  localparam int RECV_STALL_PCT [NUM_PHASES] = '{0, 0, 70, 17, 0};

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     op_valid = 1'b0;
  logic     op_stall;
  alu_in_t  op_word = '0;
  logic     res_valid;
  logic     res_stall = 1'b0;
  alu_out_t res_word;

  alu_case_t pending_cases[$];
  alu_out_t  expected_words[$];
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        mismatch_count = 0;
  int        hang_cycles = 0;

  eight_bit_alu_with_flags_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (op_valid),
    .op_stall  (op_stall),
    .op_word   (op_word),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_word  (res_word)
  );

  always #5 clk = ~clk;

  // Result byte and new flags for one operation word
  function automatic alu_out_t calc_alu_word(alu_in_t w);
    alu_out_t   o;
    logic [8:0] sum;
    logic [7:0] addend;
    logic [7:0] diff;
    logic       flags_follow;
    o.result       = w.reg_value;
    o.negative_out = w.negative_in;
    o.zero_out     = w.zero_in;
    o.carry_out    = w.carry_in;
    o.overflow_out = w.overflow_in;
    flags_follow   = 1'b1;
    case (w.op)
      OP_ADD, OP_SUB: begin
        // subtract is add of the inverted operand, carry acting as not-borrow
        addend = (w.op == OP_SUB) ? ~w.operand : w.operand;
        sum = {1'b0, w.reg_value} + {1'b0, addend} + {8'd0, w.carry_in};
        o.result       = sum[7:0];
        o.carry_out    = sum[8];
        o.overflow_out = (w.reg_value[7] ^ sum[7]) & (addend[7] ^ sum[7]);
      end
      OP_CMP: begin
        diff = w.reg_value - w.operand;
        flags_follow   = 1'b0;
        o.zero_out     = (w.reg_value == w.operand);
        o.carry_out    = (w.reg_value >= w.operand);
        o.negative_out = diff[7];
      end
      OP_AND:  o.result = w.reg_value & w.operand;
      OP_OR:   o.result = w.reg_value | w.operand;
      OP_XOR:  o.result = w.reg_value ^ w.operand;
      OP_SHL: begin
        o.result    = {w.operand[6:0], 1'b0};
        o.carry_out = w.operand[7];
      end
      OP_SHR: begin
        o.result    = {1'b0, w.operand[7:1]};
        o.carry_out = w.operand[0];
      end
      OP_ROL: begin
        o.result    = {w.operand[6:0], w.carry_in};
        o.carry_out = w.operand[7];
      end
      OP_ROR: begin
        o.result    = {w.carry_in, w.operand[7:1]};
        o.carry_out = w.operand[0];
      end
      OP_INC:  o.result = w.operand + 8'd1;
      OP_DEC:  o.result = w.operand - 8'd1;
      OP_BIT: begin
        flags_follow   = 1'b0;
        o.negative_out = w.operand[7];
        o.overflow_out = w.operand[6];
        o.zero_out     = ((w.operand & w.reg_value) == 8'd0);
      end
      OP_LOAD: o.result = w.operand;
      default: flags_follow = 1'b0;
    endcase
    if (flags_follow) begin
      o.negative_out = o.result[7];
      o.zero_out     = (o.result == 8'd0);
    end
    return o;
  endfunction

  // Lean on the sign and carry boundaries now and then
  function automatic logic [7:0] pick_byte();
    logic [7:0] corners [4];
    corners = '{8'h00, 8'h7F, 8'h80, 8'hFF};
    if ($urandom_range(0, 7) == 0)
      return corners[2'($urandom_range(0, 3))];
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic report_mismatch(string what, logic [7:0] want, logic [7:0] got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t: %s mismatch: expected %02h, got %02h", $realtime, what, want, got);
  endtask

  // Hold the word until taken; idle the channel at the current rate first
  task automatic send_word(alu_case_t c);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      op_valid <= 1'b0;
      @(posedge clk);
    end
    pending_cases.push_back(c);
    op_valid <= 1'b1;
    op_word  <= c.word;
    @(posedge clk);
    while (op_stall)
      @(posedge clk);
  endtask

  always @(posedge clk)
    res_stall <= ($urandom_range(0, 99) < recv_stall_pct);

  always @(posedge clk) begin : watch
    alu_case_t c;
    alu_out_t  want;
    logic      moved;
    moved = 1'b0;
    if (!rst) begin
      if (op_valid && !op_stall) begin
        moved = 1'b1;
        c = pending_cases.pop_front();
        expected_words.push_back(c.typed ? c.want : calc_alu_word(op_word));
      end
      if (res_valid && !res_stall) begin
        moved = 1'b1;
        if (expected_words.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: result word %03h with nothing outstanding", $realtime, res_word);
        end else begin
          want = expected_words.pop_front();
          if (want.result != res_word.result)
            report_mismatch("result", want.result, res_word.result);
          if (want.negative_out != res_word.negative_out)
            report_mismatch("N flag", {7'd0, want.negative_out},
                            {7'd0, res_word.negative_out});
          if (want.zero_out != res_word.zero_out)
            report_mismatch("Z flag", {7'd0, want.zero_out},
                            {7'd0, res_word.zero_out});
          if (want.carry_out != res_word.carry_out)
            report_mismatch("C flag", {7'd0, want.carry_out},
                            {7'd0, res_word.carry_out});
          if (want.overflow_out != res_word.overflow_out)
            report_mismatch("V flag", {7'd0, want.overflow_out},
                            {7'd0, res_word.overflow_out});
        end
      end
    end
    hang_cycles = moved ? 0 : hang_cycles + 1;
    if (hang_cycles >= HANG_LIMIT) begin
      $display("eight_bit_alu_with_flags_unit verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    alu_case_t c;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED_CASES[i])
      send_word(DIRECTED_CASES[i]);

    for (int p = 0; p < NUM_PHASES; p++) begin
      send_idle_pct  = SEND_IDLE_PCT[p];
      recv_stall_pct = RECV_STALL_PCT[p];
      for (int k = 0; k < NUM_RANDOM / NUM_PHASES; k++) begin
        c = '0;
        c.word.op          = 4'($urandom_range(0, 15));
        c.word.reg_value   = pick_byte();
        c.word.operand     = pick_byte();
        c.word.carry_in    = 1'($urandom_range(0, 1));
        c.word.overflow_in = 1'($urandom_range(0, 1));
        c.word.negative_in = 1'($urandom_range(0, 1));
        c.word.zero_in     = 1'($urandom_range(0, 1));
        send_word(c);
      end
    end
    op_valid <= 1'b0;

    // drain, then wait on for any stray results
    while (expected_words.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_words.size() != 0)
      mismatch_count++;

    if (mismatch_count == 0)
      $display("eight_bit_alu_with_flags_unit verification clean");
    else
      $display("eight_bit_alu_with_flags_unit verification failed");
    $finish;
  end

endmodule
